// ===== hdl/tdp_pkg.sv =====
// Shared types and microcode for the trial-division prime tester.
// Holds the control word layout, branch conditions and the program ROM.
// No dependencies.
`default_nettype none

package tdp_pkg;

    localparam int UPC_W = 3;

    // Program step addresses
    localparam logic [UPC_W-1:0] STEP_LOAD  = 3'd0;
    localparam logic [UPC_W-1:0] STEP_SMALL = 3'd1;
    localparam logic [UPC_W-1:0] STEP_BOUND = 3'd2;
    localparam logic [UPC_W-1:0] STEP_DIV   = 3'd3;
    localparam logic [UPC_W-1:0] STEP_REM   = 3'd4;
    localparam logic [UPC_W-1:0] STEP_EMIT  = 3'd5;

    typedef enum logic [2:0] {
        COND_IN_VALID = 3'd0,
        COND_SMALL    = 3'd1,
        COND_OVER     = 3'd2,
        COND_CNT_ZERO = 3'd3,
        COND_REM_ZERO = 3'd4,
        COND_OUT_FREE = 3'd5
    } cond_t;

    typedef struct packed {
        cond_t            cond;
        logic [UPC_W-1:0] tgt_hit;
        logic [UPC_W-1:0] tgt_miss;
        logic             ld;
        logic             res_we;
        logic             res_val;
        logic             div_init;
        logic             div_step;
        logic             adv_d;
        logic             emit;
    } ucode_t;

    // Datapath controls issued by the sequencer (ld_go/emit_go gated by branch hit)
    typedef struct packed {
        logic in_ready;
        logic ld_go;
        logic res_we;
        logic res_val;
        logic div_init;
        logic div_step;
        logic adv_d;
        logic emit_go;
    } ctl_t;

    // Branch flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic below_two;
        logic over;
        logic cnt_zero;
        logic rem_zero;
    } stat_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        w = '0;
        case (addr)
            STEP_LOAD: begin
                w.cond = COND_IN_VALID; w.tgt_hit = STEP_SMALL; w.tgt_miss = STEP_LOAD;
                w.ld = 1'b1;
            end
            STEP_SMALL: begin
                w.cond = COND_SMALL; w.tgt_hit = STEP_EMIT; w.tgt_miss = STEP_BOUND;
                w.res_we = 1'b1; w.res_val = 1'b0;
            end
            STEP_BOUND: begin
                w.cond = COND_OVER; w.tgt_hit = STEP_EMIT; w.tgt_miss = STEP_DIV;
                w.res_we = 1'b1; w.res_val = 1'b1; w.div_init = 1'b1;
            end
            STEP_DIV: begin
                w.cond = COND_CNT_ZERO; w.tgt_hit = STEP_REM; w.tgt_miss = STEP_DIV;
                w.div_step = 1'b1;
            end
            STEP_REM: begin
                w.cond = COND_REM_ZERO; w.tgt_hit = STEP_EMIT; w.tgt_miss = STEP_BOUND;
                w.res_we = 1'b1; w.res_val = 1'b0; w.adv_d = 1'b1;
            end
            STEP_EMIT: begin
                w.cond = COND_OUT_FREE; w.tgt_hit = STEP_LOAD; w.tgt_miss = STEP_EMIT;
                w.emit = 1'b1;
            end
            default: begin
                w.cond = COND_OUT_FREE; w.tgt_hit = STEP_LOAD; w.tgt_miss = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tdp_sequencer.sv =====
// Microcode sequencer: step counter, program ROM and conditional branch.
// Depends on tdp_pkg.
`default_nettype none

module tdp_sequencer
    import tdp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire stat_t stat,
    output ctl_t       ctl
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    ucode_t           uw;
    logic             hit;

    assign uw = ucode_rom(upc_reg);

    always_comb begin
        case (uw.cond)
            COND_IN_VALID: hit = stat.in_valid;
            COND_SMALL:    hit = stat.below_two;
            COND_OVER:     hit = stat.over;
            COND_CNT_ZERO: hit = stat.cnt_zero;
            COND_REM_ZERO: hit = stat.rem_zero;
            COND_OUT_FREE: hit = stat.out_free;
            default:       hit = 1'b0;
        endcase
    end

    assign upc_next = hit ? uw.tgt_hit : uw.tgt_miss;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_LOAD;
        end else begin
            upc_reg <= upc_next;
        end
    end

    always_comb begin
        ctl.in_ready = uw.ld;
        ctl.ld_go    = uw.ld & hit;
        ctl.res_we   = uw.res_we;
        ctl.res_val  = uw.res_val;
        ctl.div_init = uw.div_init;
        ctl.div_step = uw.div_step;
        ctl.adv_d    = uw.adv_d;
        ctl.emit_go  = uw.emit & hit;
    end

endmodule

`default_nettype wire

// ===== hdl/tdp_datapath.sv =====
// Datapath: candidate, trial divisor, running square, bit-serial remainder.
// Depends on tdp_pkg; driven by tdp_sequencer controls.
`default_nettype none

module tdp_datapath
    import tdp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire ctl_t                  ctl,
    input  wire logic [DATA_WIDTH-1:0] cand,
    output stat_t                      flags,
    output logic                       res
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] n_reg, d_reg, r_reg;
    logic [DATA_WIDTH:0]   sq_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  res_reg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;

    // One restoring step: bring in the next candidate bit, subtract if it fits
    assign shifted = {r_reg, n_reg[cnt_reg]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (ctl.ld_go) begin
            n_reg  <= cand;
            d_reg  <= DATA_WIDTH'(2);
            sq_reg <= (DATA_WIDTH + 1)'(4);
        end else if (ctl.adv_d) begin
            // (d+1)^2 = d^2 + 2d + 1
            d_reg  <= d_reg + DATA_WIDTH'(1);
            sq_reg <= sq_reg + {d_reg, 1'b1};
        end
        if (ctl.div_init) begin
            r_reg   <= '0;
            cnt_reg <= CNT_W'(DATA_WIDTH - 1);
        end else if (ctl.div_step) begin
            r_reg   <= diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (ctl.res_we) begin
            res_reg <= ctl.res_val;
        end
    end

    always_comb begin
        flags.in_valid  = 1'b0;
        flags.out_free  = 1'b0;
        flags.below_two = n_reg[DATA_WIDTH-1] || (n_reg[DATA_WIDTH-1:1] == '0);
        flags.over      = sq_reg > {1'b0, n_reg};
        flags.cnt_zero  = (cnt_reg == '0);
        flags.rem_zero  = (r_reg == '0);
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== hdl/trial_division_prime_test.sv =====
// Trial-division prime test, one signed DATA_WIDTH-bit candidate per transaction.
// A candidate below 2 goes straight to emit; otherwise each trial divisor costs one bound
// check, DATA_WIDTH remainder steps and one remainder test, until the bound is passed (prime)
// or a zero remainder is found (composite).
// A new candidate is taken only after the last result is emitted, and a held result stalls emit.
// Reset (aresetn low, synchronous) returns the sequencer to its load step and empties the output.
`default_nettype none

module trial_division_prime_test
    import tdp_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,   // [DATA_WIDTH-1:0] candidate
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata    // [0] is_prime
);

    ctl_t  ctl;
    stat_t dp_flags;
    stat_t stat;
    logic  res;
    logic  m_tvalid_reg, m_tvalid_next;
    logic  is_prime_reg;

    tdp_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    tdp_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk  (aclk),
        .ctl   (ctl),
        .cand  (s_tdata[DATA_WIDTH-1:0]),
        .flags (dp_flags),
        .res   (res)
    );

    always_comb begin
        stat          = dp_flags;
        stat.in_valid = s_tvalid;
        stat.out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctl.emit_go) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (ctl.emit_go) begin
            is_prime_reg <= res;
        end
    end

    assign s_tready = ctl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, is_prime_reg};

    // Busy after a candidate is taken
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a candidate is in work");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit_go |-> (!m_tvalid_reg || m_tready))
        else $error("result issued over a pending one");

    // Output valid only rises from the emit step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(ctl.emit_go))
        else $error("output valid without emit");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for trial_division_prime_test: directed probes, then random candidates.
// Predicts each verdict by trial division at 32 bits, but for the probes whose verdict is typed in;
// depends only on the block's ports. Random idle on both stream sides plus one long hold-off on the result side.
`default_nettype none

module tb_top;

    localparam int DATA_WIDTH  = 32;
    localparam int TDATA_W     = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int PROBE_COUNT = 24;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  fixed;    // verdict typed in below, not predicted
        logic                  verdict;
    } probe_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;   // [31:0] candidate
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;        // [0] is_prime

    bit   expected_verdicts [$];
    int   mismatch_count = 0;
    int   verdicts_seen = 0;
    bit   calm = 1'b0;
    bit   held_off = 1'b0;

    probe_t probe_table [0:PROBE_COUNT-1] = '{
        '{32'h0000_0000, 1'b1, 1'b0},
        '{32'h0000_0001, 1'b1, 1'b0},
        '{32'h0000_0002, 1'b1, 1'b1},
        '{32'h0000_0003, 1'b1, 1'b1},
        '{32'h0000_0004, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0},
        '{32'h8000_0001, 1'b1, 1'b0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0},
        '{32'h7FFF_FFFE, 1'b1, 1'b0},
        '{32'h4000_0000, 1'b1, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0},
        '{32'h0000_0006, 1'b0, 1'b0},
        '{32'h0000_0009, 1'b0, 1'b0},
        '{32'h0000_0019, 1'b0, 1'b0},
        '{32'h0000_0031, 1'b0, 1'b0},
        '{32'h0000_0061, 1'b0, 1'b0},
        '{32'h0000_0079, 1'b0, 1'b0},
        '{32'h0000_03FD, 1'b0, 1'b0},
        '{32'h0000_0400, 1'b0, 1'b0},
        '{32'h0000_F619, 1'b0, 1'b0},
        '{32'h0000_FFF1, 1'b0, 1'b0},
        '{32'h0001_0001, 1'b0, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0}
    };

    trial_division_prime_test #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    // Trial division with the exact bound d <= n / d; sign bit set means below two.
    function automatic bit prime_verdict(input logic [DATA_WIDTH-1:0] raw);
        longint unsigned n;
        longint unsigned d;
        n = 64'(raw);
        if (raw[DATA_WIDTH-1])
            return 1'b0;
        if (n <= 1)
            return 1'b0;
        for (d = 2; d <= n / d; d++) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones; none while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(30, 80);
    endfunction

    // Keep primes small enough to finish fast; large values exit on a small factor.
    function automatic logic [DATA_WIDTH-1:0] pick_candidate();
        logic [DATA_WIDTH-1:0] v;
        int r;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 35) begin
            v = $urandom_range(0, 1023);
        end else if (r < 55) begin
            v = $urandom_range(1024, 65535);
        end else if (r < 63) begin
            v = $urandom_range(65536, 262143);
        end else if (r < 78) begin
            v[DATA_WIDTH-1] = 1'b1;
        end else if (r < 90) begin
            v[DATA_WIDTH-1] = 1'b0;
            v[0] = 1'b0;
        end else begin
            v = $urandom_range(0, 715827882) * 3;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one candidate, hold it until the transaction completes, then queue its verdict.
    task automatic offer_candidate(input logic [DATA_WIDTH-1:0] value, input bit verdict);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(value);
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected_verdicts.insert(expected_verdicts.size(), verdict);
    endtask

    // Result side: random stalls, and one long hold-off that backs up the input.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held_off && verdicts_seen >= 12) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        bit want;
        if (aresetn && m_tvalid && m_tready) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result is_prime=%0b", m_tdata[0]));
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("is_prime=%0b, want %0b", m_tdata[0], want));
            end
        end
    end

    initial begin
        logic [DATA_WIDTH-1:0] cand;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PROBE_COUNT; i++) begin
            cand = probe_table[i].value;
            offer_candidate(cand,
                probe_table[i].fixed ? probe_table[i].verdict : prime_verdict(cand));
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 40 && i < 60);
            cand = pick_candidate();
            offer_candidate(cand, prime_verdict(cand));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        wait (expected_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
